>>> rtl/udrb_pkg.sv
// ----------------------------------------------------------------------------
// udrb_pkg: shared types and constants of the UART dual ring buffer
// Holds the event codes and the fixed field widths used by the interfaces
// and by the top level.
// ----------------------------------------------------------------------------
package udrb_pkg;

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;

  // Event codes carried in the operation field.
  typedef enum logic [OP_W-1:0] {
    OP_LINE_RX    = 2'd0,
    OP_HOST_READ  = 2'd1,
    OP_HOST_WRITE = 2'd2,
    OP_TX_READY   = 2'd3
  } udrb_op_e;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

>>> rtl/udrb_in_if.sv
// ----------------------------------------------------------------------------
// udrb_in_if: event channel of the UART dual ring buffer
// Carries one event item (operation code and data byte) with valid/ready.
// ----------------------------------------------------------------------------
interface udrb_in_if;
  logic                            valid;
  logic                            ready;
  logic [udrb_pkg::OP_W-1:0]       operation;
  udrb_pkg::byte_t                 data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

>>> rtl/udrb_out_if.sv
// ----------------------------------------------------------------------------
// udrb_out_if: result channel of the UART dual ring buffer
// Carries one result item per event with valid/ready.
// ----------------------------------------------------------------------------
interface udrb_out_if;
  logic            valid;
  logic            ready;
  udrb_pkg::byte_t read_data;
  logic            read_valid;
  logic            write_accepted;
  udrb_pkg::byte_t line_out_byte;
  logic            line_out_valid;
  logic            arrival_stored;
  logic            receive_irq_on;
  logic            transmit_irq_on;

  modport source (
    output valid, output read_data, output read_valid, output write_accepted,
    output line_out_byte, output line_out_valid, output arrival_stored,
    output receive_irq_on, output transmit_irq_on, input ready
  );
  modport sink (
    input valid, input read_data, input read_valid, input write_accepted,
    input line_out_byte, input line_out_valid, input arrival_stored,
    input receive_irq_on, input transmit_irq_on, output ready
  );
endinterface

>>> rtl/uart_dual_ring_buffer.sv
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer: receive and transmit byte rings of a UART
// Event-driven model of the interrupt-side buffering of a UART: line
// arrivals, host reads, host writes and transmitter-ready events.
// ----------------------------------------------------------------------------
// Usage: every event enters on in_i as one item (operation, data_byte) and
// produces exactly one result item on out_o, in order. Line arrivals fill the
// receive ring, host reads drain it; host writes fill the transmit ring and
// transmitter-ready events drain it. Each ring keeps one slot free, so it
// holds at most RING_DEPTH - 1 bytes. A full receive ring drops the byte and
// clears the receive interrupt enable; a full transmit ring rejects the write.
// The result of an item is registered and shown from the cycle after the item
// is accepted. One item is taken per cycle while out_o is not stalled: the
// pointer compare and update happen in the accepting cycle, and each ring
// memory is read into a registered data word beside the result flags.
// When the receiver stalls, the result register holds and in_i stays ready
// only as long as that register is free or being emptied in the same cycle.
// Reset clears all pointers (both rings empty), sets the receive interrupt
// enable and clears the transmit enable; ring contents are left as they are.
// ----------------------------------------------------------------------------
module uart_dual_ring_buffer #(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  udrb_in_if.sink     in_i,
  udrb_out_if.source  out_o
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Ring storage, no reset: a slot is only read after it has been written.
  udrb_pkg::byte_t rx_mem [RING_DEPTH];
  udrb_pkg::byte_t tx_mem [RING_DEPTH];

  logic [PTR_W-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [PTR_W-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic             rx_en_q, rx_en_d, tx_en_q, tx_en_d;

  // Result register.
  logic             out_valid_q;
  logic             rd_valid_q, rd_valid_d;
  logic             wr_acc_q, wr_acc_d;
  logic             lo_valid_q, lo_valid_d;
  logic             stored_q, stored_d;
  udrb_pkg::byte_t  rx_rdata_q, tx_rdata_q;

  logic             accept;
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [PTR_W-1:0] rx_head_nx, rx_tail_nx, tx_head_nx, tx_tail_nx;
  logic             rx_empty, rx_full, tx_empty, tx_full;
  udrb_pkg::udrb_op_e op;

  // The result register is free when empty or when it is taken this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign op         = udrb_pkg::udrb_op_e'(in_i.operation);

  assign rx_head_nx = ptr_next(rx_head_q);
  assign rx_tail_nx = ptr_next(rx_tail_q);
  assign tx_head_nx = ptr_next(tx_head_q);
  assign tx_tail_nx = ptr_next(tx_tail_q);
  assign rx_empty   = (rx_head_q == rx_tail_q);
  assign rx_full    = (rx_head_nx == rx_tail_q);
  assign tx_empty   = (tx_head_q == tx_tail_q);
  assign tx_full    = (tx_head_nx == tx_tail_q);

  // Event decode. Only one event is taken per cycle, so a ring is never
  // written and read in the same cycle.
  always_comb begin
    rx_head_d  = rx_head_q;
    rx_tail_d  = rx_tail_q;
    tx_head_d  = tx_head_q;
    tx_tail_d  = tx_tail_q;
    rx_en_d    = rx_en_q;
    tx_en_d    = tx_en_q;
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    tx_we      = 1'b0;
    tx_re      = 1'b0;
    rd_valid_d = 1'b0;
    wr_acc_d   = 1'b0;
    lo_valid_d = 1'b0;
    stored_d   = 1'b0;
    if (accept) begin
      unique case (op)
        udrb_pkg::OP_LINE_RX: begin
          if (rx_full) begin
            // Overrun: drop the byte and mask receive interrupts.
            rx_en_d = 1'b0;
          end else begin
            rx_head_d = rx_head_nx;
            rx_we     = 1'b1;
            stored_d  = 1'b1;
          end
        end
        udrb_pkg::OP_HOST_READ: begin
          if (!rx_empty) begin
            rx_tail_d  = rx_tail_nx;
            rx_re      = 1'b1;
            rd_valid_d = 1'b1;
          end
          rx_en_d = 1'b1;
        end
        udrb_pkg::OP_HOST_WRITE: begin
          if (!tx_full) begin
            tx_head_d = tx_head_nx;
            tx_we     = 1'b1;
            tx_en_d   = 1'b1;
            wr_acc_d  = 1'b1;
          end
        end
        udrb_pkg::OP_TX_READY: begin
          if (!tx_empty) begin
            tx_tail_d  = tx_tail_nx;
            tx_re      = 1'b1;
            lo_valid_d = 1'b1;
          end else begin
            tx_en_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      rx_en_q     <= 1'b1;
      tx_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      rx_en_q   <= rx_en_d;
      tx_en_q   <= tx_en_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result flags load with each accepted item and hold while stalled.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_valid_q <= rd_valid_d;
      wr_acc_q   <= wr_acc_d;
      lo_valid_q <= lo_valid_d;
      stored_q   <= stored_d;
    end
  end

  // Receive ring memory with registered read port.
  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_head_nx] <= in_i.data_byte;
    end
    if (rx_re) begin
      rx_rdata_q <= rx_mem[rx_tail_nx];
    end
  end

  // Transmit ring memory with registered read port.
  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_head_nx] <= in_i.data_byte;
    end
    if (tx_re) begin
      tx_rdata_q <= tx_mem[tx_tail_nx];
    end
  end

  // The enables are shown as they stand after the item; they change only on
  // an accept, so the current register value matches while a result waits.
  assign out_o.valid           = out_valid_q;
  assign out_o.read_data       = rd_valid_q ? rx_rdata_q : '0;
  assign out_o.read_valid      = rd_valid_q;
  assign out_o.write_accepted  = wr_acc_q;
  assign out_o.line_out_byte   = lo_valid_q ? tx_rdata_q : '0;
  assign out_o.line_out_valid  = lo_valid_q;
  assign out_o.arrival_stored  = stored_q;
  assign out_o.receive_irq_on  = rx_en_q;
  assign out_o.transmit_irq_on = tx_en_q;

endmodule
